[hdl/assert_macros.svh]
// Concurrent assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define SUA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SUA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sua_pkg.sv]
package sua_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int MAX_RESULTS      = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_DUPLICATE = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_DUMPED    = 3'd3;
    localparam logic [2:0] STS_EMPTY     = 3'd4;
    localparam logic [2:0] STS_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] entry;
        logic [4:0]  position;
        logic [5:0]  count;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_DUMP,
        ST_RESP_INS,
        ST_RESP_DUP,
        ST_RESP_FULL,
        ST_RESP_CLR,
        ST_RESP_EMPTY
    } sua_state_t;

    typedef struct packed {
        logic       accept;
        logic       clear_count;
        logic       scan_step;
        logic       mark_pos;
        logic       shift_start;
        logic       shift_step;
        logic       place;
        logic       dump_step;
        logic       load_out;
        logic [2:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_at_end;
        logic       hit_eq;
        logic       hit_lt;
        logic       full;
        logic       idx_at_pos;
        logic       dump_last;
        logic       out_free;
        logic       is_empty;
    } dp_stat_t;

endpackage

[hdl/sorted_unique_address_set_unit.sv]
// Sorted set of up to CAPACITY unique 32-bit addresses in a one-read, one-write entry memory.
// Insert walks the stored entries once, one per cycle: it compares upward until it finds the
// slot or a duplicate, then moves the larger entries up one place from the top and writes the
// new address. A duplicate or full insert returns after its compare walk. Clear and a dump
// of an empty set go straight from idle to their response; a dump gives one beat per cycle
// from the registered memory read, stalled only by out_ready. A result waits in an output
// register while the next item is taken.
module sorted_unique_address_set_unit import sua_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sua_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sua_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[hdl/sua_ctrl.sv]
module sua_ctrl import sua_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    sua_state_t state_reg;
    sua_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (stat.cmd)
                        CMD_INSERT: state_next = ST_SCAN;
                        CMD_CLEAR:  state_next = ST_RESP_CLR;
                        CMD_DUMP:   state_next = stat.is_empty ? ST_RESP_EMPTY : ST_DUMP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.idx_at_end)
                begin
                    state_next = stat.full ? ST_RESP_FULL : ST_PLACE;
                end
                else if (stat.hit_eq)
                begin
                    state_next = ST_RESP_DUP;
                end
                else if (stat.hit_lt)
                begin
                    state_next = stat.full ? ST_RESP_FULL : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (stat.idx_at_pos)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_RESP_INS;
            end
            ST_DUMP:
            begin
                if (stat.out_free && stat.dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP_INS, ST_RESP_DUP, ST_RESP_FULL, ST_RESP_CLR, ST_RESP_EMPTY:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept      = 1'b1;
                    cmd.clear_count = (stat.cmd == CMD_CLEAR);
                end
            end
            ST_SCAN:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.mark_pos = !stat.full;
                end
                else if (stat.hit_eq)
                begin
                    cmd.mark_pos = 1'b1;
                end
                else if (stat.hit_lt)
                begin
                    cmd.mark_pos    = !stat.full;
                    cmd.shift_start = !stat.full;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
            end
            ST_DUMP:
            begin
                cmd.out_status = STS_DUMPED;
                if (stat.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.dump_step = !stat.dump_last;
                end
            end
            ST_RESP_INS:
            begin
                cmd.out_status = STS_INSERTED;
                cmd.load_out   = stat.out_free;
            end
            ST_RESP_DUP:
            begin
                cmd.out_status = STS_DUPLICATE;
                cmd.load_out   = stat.out_free;
            end
            ST_RESP_FULL:
            begin
                cmd.out_status = STS_FULL;
                cmd.load_out   = stat.out_free;
            end
            ST_RESP_CLR:
            begin
                cmd.out_status = STS_CLEARED;
                cmd.load_out   = stat.out_free;
            end
            ST_RESP_EMPTY:
            begin
                cmd.out_status = STS_EMPTY;
                cmd.load_out   = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/sua_datapath.sv]
`include "assert_macros.svh"

module sua_datapath import sua_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rd_data_reg;
    logic [31:0]   addr_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] idx_p1;
    logic          out_valid_reg;
    out_item_t     out_data_reg;
    out_item_t     res;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [7:0]    dump_p1;
    logic [CW+4:0] idx_w;
    logic [CW+4:0] pos_w;
    logic [CW+5:0] count_w;

    assign idx_p1 = idx_reg + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step || cmd.dump_step)
        begin
            idx_next = idx_p1;
        end
        else if (cmd.shift_start)
        begin
            idx_next = count_reg - 1'b1;
        end
        else if (cmd.shift_step && !stat.idx_at_pos)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.place)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign rd_en   = (idx_next < CW'(CAPACITY));
    assign rd_addr = idx_next[AW-1:0];
    assign wr_en   = cmd.shift_step || cmd.place;
    assign wr_addr = cmd.place ? pos_reg[AW-1:0] : idx_p1[AW-1:0];
    assign wr_data = cmd.place ? addr_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= in_data.address;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.mark_pos)
            begin
                pos_reg <= idx_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dump_p1 = 8'(idx_reg) + 8'd1;
    assign idx_w   = {5'd0, idx_reg};
    assign pos_w   = {5'd0, pos_reg};
    assign count_w = {6'd0, count_reg};

    always_comb
    begin
        res          = '0;
        res.status   = cmd.out_status;
        res.count    = count_w[5:0];
        res.last     = 1'b1;
        case (cmd.out_status)
            STS_DUMPED:
            begin
                res.entry    = rd_data_reg;
                res.position = idx_w[4:0];
                res.last     = stat.dump_last;
            end
            STS_INSERTED, STS_DUPLICATE:
            begin
                res.entry    = addr_reg;
                res.position = pos_w[4:0];
            end
            STS_FULL:
            begin
                res.entry = addr_reg;
            end
            default:
            begin
                res.entry = '0;
            end
        endcase
    end

    assign stat.cmd        = in_data.cmd;
    assign stat.idx_at_end = (idx_reg == count_reg);
    assign stat.hit_eq     = (rd_data_reg == addr_reg);
    assign stat.hit_lt     = (addr_reg < rd_data_reg);
    assign stat.full       = (count_reg >= CW'(CAPACITY));
    assign stat.idx_at_pos = (idx_reg == pos_reg);
    assign stat.dump_last  = (dump_p1 == 8'(count_reg)) || (dump_p1 == 8'(MAX_RESULTS));
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.is_empty   = (count_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SUA_ASSERT(a_count_bound, (count_reg <= CW'(CAPACITY)), "count above capacity")
    `SUA_ASSERT(a_load_free, (cmd.load_out |-> stat.out_free), "result loaded over held beat")
    `SUA_ASSERT(a_place_incr, (cmd.place |=> (count_reg == $past(count_reg) + 1'b1)), "bad count")
    `SUA_ASSERT(a_shift_above, (cmd.shift_step |-> (idx_reg >= pos_reg)), "shift below slot")

endmodule
